// ===== hw/rtl/assert_macros.svh =====
// Assertion shorthands shared by the clock modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ===== hw/rtl/tca_pkg.sv =====
package tca_pkg;

	localparam int unsigned TICK_HZ    = 100;
	localparam int unsigned RES_STEPS  = 20;
	localparam int unsigned NS_PER_SEC = 1000000000;
	localparam int unsigned MAX_RES    = NS_PER_SEC / TICK_HZ;
	localparam int unsigned MIN_RES    = MAX_RES / RES_STEPS;

	localparam int unsigned HZ_W       = 5;
	localparam int unsigned TICK_HZ_W  = $clog2(TICK_HZ + 1);
	localparam int unsigned PROD_W     = 24 + TICK_HZ_W;
	localparam int unsigned DSH_W      = PROD_W + HZ_W;
	localparam int unsigned DIV_CNT_W  = $clog2(HZ_W + 1);

	localparam logic [30:0] NS_SEC_31  = 31'(NS_PER_SEC);
	localparam logic [29:0] NS_SEC_30  = 30'(NS_PER_SEC);
	localparam logic [HZ_W-1:0] HZ_MAX = '1;

	typedef enum logic [1:0] {
		MODE_TICK,
		MODE_SET_TIME,
		MODE_SET_ALARM,
		MODE_REQ_RES
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMD,
		ST_TICK,
		ST_ALARM,
		ST_MUL,
		ST_DIV,
		ST_RELOAD,
		ST_WRITE
	} state_t;

	typedef struct packed {
		logic accept;
		logic exec_cmd;
		logic tick_time;
		logic tick_alarm;
		logic div_init;
		logic div_step;
		logic reload;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic rate_due;
		logic div_last;
	} stat_t;

	// A resolution is legal only as a whole number of minimum steps up to the maximum.
	function automatic logic res_valid(input logic [23:0] r);
		logic ok;
		ok = 1'b0;
		for (int k = 1; k <= int'(RES_STEPS); k++) begin
			if (r == 24'(k * MIN_RES)) ok = 1'b1;
		end
		return ok;
	endfunction

endpackage

// ===== hw/rtl/tick_clock_with_alarm.sv =====
// Tick-driven time-of-day clock with one alarm.
// Input channel (in_valid/in_stall) takes one transaction per command: a tick, a
// set-time, a set-alarm or a resolution request, selected by mode. The output
// channel (out_valid/out_stall) returns exactly one result per input transaction.
// Set-time, set-alarm and resolution requests are carried out in the command state
// and then written out. A tick advances the time, then checks the alarm and the
// rate countdown, then is written out; on a tick where a pending resolution takes
// effect the new per-boundary tick count is first found by a bit-serial divider
// that takes an overflow step and then one quotient bit per cycle. The block
// handles one transaction at a time; a new one is taken in the cycle after the
// previous result is loaded. A finished result sits in the output
// register while the next transaction is accepted and processed; if the receiver
// still stalls when the next result is ready, the block waits and holds in_stall.
// Reset clears the time and alarm, sets the resolution to its maximum and leaves
// no result pending.
module tick_clock_with_alarm import tca_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [31:0] arg_sec,
	input  logic [29:0] arg_nsec,
	input  logic [23:0] req_resolution,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        status,
	output logic [31:0] now_sec,
	output logic [29:0] now_nsec,
	output logic        alarm_fired,
	output logic [31:0] fire_sec,
	output logic [29:0] fire_nsec,
	output logic [4:0]  ticks_left,
	output logic        rate_changed,
	output logic [23:0] resolution_now
);

	cmd_t  cmd;
	stat_t stat;

	tca_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	tca_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.mode           (mode),
		.arg_sec        (arg_sec),
		.arg_nsec       (arg_nsec),
		.req_resolution (req_resolution),
		.status         (status),
		.now_sec        (now_sec),
		.now_nsec       (now_nsec),
		.alarm_fired    (alarm_fired),
		.fire_sec       (fire_sec),
		.fire_nsec      (fire_nsec),
		.ticks_left     (ticks_left),
		.rate_changed   (rate_changed),
		.resolution_now (resolution_now)
	);

endmodule

// ===== hw/rtl/tca_dp.sv =====
`include "assert_macros.svh"

module tca_dp import tca_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output stat_t       stat,
	input  logic [1:0]  mode,
	input  logic [31:0] arg_sec,
	input  logic [29:0] arg_nsec,
	input  logic [23:0] req_resolution,
	output logic        status,
	output logic [31:0] now_sec,
	output logic [29:0] now_nsec,
	output logic        alarm_fired,
	output logic [31:0] fire_sec,
	output logic [29:0] fire_nsec,
	output logic [4:0]  ticks_left,
	output logic        rate_changed,
	output logic [23:0] resolution_now
);

	// Clock state.
	logic [31:0]      time_sec_q;
	logic [29:0]      time_nsec_q;
	logic             armed_q;
	logic [31:0]      alarm_sec_q;
	logic [29:0]      alarm_nsec_q;
	logic [23:0]      res_q;
	logic [23:0]      pend_q;
	logic [22:0]      half_q;
	logic [HZ_W-1:0]  cd_q;
	logic [HZ_W-1:0]  tph_q;

	// Current transaction and its partial result.
	mode_t            item_mode_q;
	logic [31:0]      item_sec_q;
	logic [29:0]      item_nsec_q;
	logic [23:0]      item_req_q;
	logic             status_q;
	logic             fired_q;
	logic [31:0]      fsec_q;
	logic [29:0]      fnsec_q;
	logic [HZ_W-1:0]  left_q;
	logic             changed_q;

	// Reload divider.
	logic [29:0]      div_rem_q;
	logic [DSH_W-1:0] div_dsh_q;
	logic [HZ_W-1:0]  div_quo_q;
	logic             div_sat_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;

	logic [30:0]      tick_sum;
	logic [30:0]      ns_half;
	logic [30:0]      ns_sub;
	logic             ns_wrap;
	logic             fire_now;
	logic             div_ge;
	logic [PROD_W-1:0] div_prod;
	logic [HZ_W-1:0]  hz_new;

	assign tick_sum = {1'b0, time_nsec_q} + {7'b0, res_q};
	assign ns_half  = {1'b0, time_nsec_q} + {8'b0, half_q};
	assign ns_sub   = ns_half - NS_SEC_31;
	assign ns_wrap  = ns_half >= NS_SEC_31;

	// A past nanosecond in the same second counts as due, hence the unsigned compare
	// against time plus half a resolution.
	assign fire_now = cmd.tick_alarm && armed_q &&
		((alarm_sec_q < time_sec_q) ||
		 ((alarm_sec_q == time_sec_q) && ({1'b0, alarm_nsec_q} <= ns_half)));

	assign div_prod = res_q * TICK_HZ_W'(TICK_HZ);
	assign div_ge   = {{(DSH_W-30){1'b0}}, div_rem_q} >= div_dsh_q;
	assign hz_new   = div_sat_q ? HZ_MAX :
		((div_quo_q == '0) ? HZ_W'(1) : div_quo_q);

	assign stat.rate_due = (cd_q <= HZ_W'(1)) && (pend_q != '0);
	assign stat.div_last = div_cnt_q == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_sec_q   <= '0;
			time_nsec_q  <= '0;
			armed_q      <= 1'b0;
			alarm_sec_q  <= '0;
			alarm_nsec_q <= '0;
			res_q        <= 24'(MAX_RES);
			pend_q       <= '0;
			half_q       <= 23'(MAX_RES / 2);
			cd_q         <= HZ_W'(1);
			tph_q        <= HZ_W'(1);
		end else begin
			if (cmd.exec_cmd) begin
				case (item_mode_q)
					MODE_SET_TIME: begin
						time_sec_q  <= item_sec_q;
						time_nsec_q <= item_nsec_q;
						armed_q     <= 1'b0;
					end
					MODE_SET_ALARM: begin
						alarm_sec_q  <= item_sec_q;
						alarm_nsec_q <= item_nsec_q;
						armed_q      <= 1'b1;
					end
					MODE_REQ_RES: begin
						if (res_valid(item_req_q) && (item_req_q != res_q)) begin
							pend_q <= item_req_q;
						end
					end
					default: ;
				endcase
			end
			if (cmd.tick_time) begin
				if (tick_sum < NS_SEC_31) begin
					time_nsec_q <= tick_sum[29:0];
				end else begin
					time_sec_q  <= time_sec_q + 32'd1;
					time_nsec_q <= '0;
				end
			end
			if (fire_now) armed_q <= 1'b0;
			if (cmd.tick_alarm) begin
				if (cd_q <= HZ_W'(1)) begin
					if (pend_q != '0) begin
						res_q  <= pend_q;
						half_q <= pend_q[23:1];
						pend_q <= '0;
					end else begin
						cd_q <= tph_q;
					end
				end else begin
					cd_q <= cd_q - HZ_W'(1);
				end
			end
			if (cmd.reload) begin
				tph_q <= hz_new;
				cd_q  <= hz_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			item_mode_q <= mode_t'(mode);
			item_sec_q  <= arg_sec;
			item_nsec_q <= arg_nsec;
			item_req_q  <= req_resolution;
			status_q    <= 1'b0;
			fired_q     <= 1'b0;
			fsec_q      <= '0;
			fnsec_q     <= '0;
			changed_q   <= 1'b0;
			left_q      <= cd_q;
		end
		if (cmd.exec_cmd && (item_mode_q == MODE_REQ_RES) && !res_valid(item_req_q)) begin
			status_q <= 1'b1;
		end
		if (fire_now) begin
			fired_q <= 1'b1;
			fsec_q  <= time_sec_q + {31'b0, ns_wrap};
			fnsec_q <= ns_wrap ? ns_sub[29:0] : ns_half[29:0];
		end
		if (cmd.tick_alarm) begin
			if (cd_q <= HZ_W'(1)) begin
				left_q <= '0;
				if (pend_q != '0) changed_q <= 1'b1;
			end else begin
				left_q <= cd_q - HZ_W'(1);
			end
		end
		// Reload is floor(1e9 / (resolution * TICK_HZ)), one quotient bit per cycle.
		// The first step only detects a quotient too large for the field.
		if (cmd.div_init) begin
			div_rem_q <= NS_SEC_30;
			div_dsh_q <= {div_prod, {HZ_W{1'b0}}};
			div_quo_q <= '0;
			div_sat_q <= 1'b0;
			div_cnt_q <= DIV_CNT_W'(HZ_W);
		end
		if (cmd.div_step) begin
			if (div_cnt_q == DIV_CNT_W'(HZ_W)) begin
				div_sat_q <= div_ge;
			end else begin
				if (div_ge) div_rem_q <= div_rem_q - div_dsh_q[29:0];
				div_quo_q <= {div_quo_q[HZ_W-2:0], div_ge};
			end
			div_dsh_q <= div_dsh_q >> 1;
			div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
		end
		if (cmd.load_out) begin
			status         <= status_q;
			now_sec        <= time_sec_q;
			now_nsec       <= time_nsec_q;
			alarm_fired    <= fired_q;
			fire_sec       <= fsec_q;
			fire_nsec      <= fnsec_q;
			ticks_left     <= left_q;
			rate_changed   <= changed_q;
			resolution_now <= res_q;
		end
	end

	`ASSERT_IMPL(a_tph_nonzero, clk, arst_n, 1'b1, tph_q != '0)
	`ASSERT_IMPL(a_res_range, clk, arst_n, 1'b1, (res_q >= 24'(MIN_RES)) && (res_q <= 24'(MAX_RES)))
	`ASSERT_NEXT(a_fire_disarms, clk, arst_n, fire_now, !armed_q && fired_q)

endmodule

// ===== hw/rtl/tca_ctrl.sv =====
`include "assert_macros.svh"

module tca_ctrl import tca_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] mode,
	output logic       out_valid,
	input  logic       out_stall,
	output cmd_t       cmd,
	input  stat_t      stat
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall  = state_q != ST_IDLE;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = (mode_t'(mode) == MODE_TICK) ? ST_TICK : ST_CMD;
				end
			end
			ST_CMD: begin
				cmd.exec_cmd = 1'b1;
				state_d      = ST_WRITE;
			end
			ST_TICK: begin
				cmd.tick_time = 1'b1;
				state_d       = ST_ALARM;
			end
			ST_ALARM: begin
				cmd.tick_alarm = 1'b1;
				state_d        = stat.rate_due ? ST_MUL : ST_WRITE;
			end
			ST_MUL: begin
				cmd.div_init = 1'b1;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) state_d = ST_RELOAD;
			end
			ST_RELOAD: begin
				cmd.reload = 1'b1;
				state_d    = ST_WRITE;
			end
			ST_WRITE: begin
				if (slot_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	`ASSERT_NEXT(a_accept_busy, clk, arst_n, cmd.accept, in_stall)
	`ASSERT_NEXT(a_write_waits, clk, arst_n,
		(state_q == ST_WRITE) && out_valid_q && out_stall, state_q == ST_WRITE)

endmodule

// ===== bench/testbench.sv =====
module testbench import tca_pkg::*; ();

	localparam int ITEM_TARGET     = 1850;
	localparam int MAX_WAIT        = 18;
	localparam int IDLE_LIMIT      = 2000;
	localparam int PRESSURE_AT     = 900;
	localparam int PRESSURE_CYCLES = 300;
	localparam int DRAIN_CYCLES    = 40;
	localparam longint NS_L        = 1000000000;

	typedef struct {
		mode_t       op;
		logic [31:0] sec;
		logic [29:0] nsec;
		logic [23:0] req;
	} command_t;

	typedef struct {
		logic        status;
		logic [31:0] now_sec;
		logic [29:0] now_nsec;
		logic        alarm_fired;
		logic [31:0] fire_sec;
		logic [29:0] fire_nsec;
		logic [4:0]  ticks_left;
		logic        rate_changed;
		logic [23:0] resolution_now;
	} clock_reading_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  mode = 2'b00;
	logic [31:0] arg_sec = '0;
	logic [29:0] arg_nsec = '0;
	logic [23:0] req_resolution = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        status;
	logic [31:0] now_sec;
	logic [29:0] now_nsec;
	logic        alarm_fired;
	logic [31:0] fire_sec;
	logic [29:0] fire_nsec;
	logic [4:0]  ticks_left;
	logic        rate_changed;
	logic [23:0] resolution_now;

	tick_clock_with_alarm dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.arg_sec(arg_sec),
		.arg_nsec(arg_nsec),
		.req_resolution(req_resolution),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.now_sec(now_sec),
		.now_nsec(now_nsec),
		.alarm_fired(alarm_fired),
		.fire_sec(fire_sec),
		.fire_nsec(fire_nsec),
		.ticks_left(ticks_left),
		.rate_changed(rate_changed),
		.resolution_now(resolution_now)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	command_t       pending_commands[$];
	clock_reading_t expected_readings[$];
	command_t       next_cmd;
	clock_reading_t predicted_reading;
	clock_reading_t want;
	int             command_total;
	int             commands_sent;
	int             readings_seen;
	int             errors = 0;
	int             tx_gap;
	int             tx_phase_left = 0;
	bit             tx_busy;
	int             rx_wait;
	int             rx_phase_left = 0;
	bit             rx_busy;
	int             idle_cycles = 0;

	// Predicted clock state.
	logic [31:0] clk_sec;
	logic [29:0] clk_nsec;
	logic        alm_armed;
	logic [31:0] alm_sec;
	logic [29:0] alm_nsec;
	logic [23:0] res_ns;
	logic [23:0] res_pending;
	logic [22:0] res_half;
	logic [4:0]  hz_countdown;
	logic [4:0]  hz_reload;

	task automatic reset_clock_model();
		clk_sec = '0;
		clk_nsec = '0;
		alm_armed = 1'b0;
		alm_sec = '0;
		alm_nsec = '0;
		res_ns = 24'(MAX_RES);
		res_pending = '0;
		res_half = 23'(MAX_RES / 2);
		hz_countdown = 5'd1;
		hz_reload = 5'd1;
	endtask

	task automatic advance_clock(input command_t c, output clock_reading_t r);
		logic [31:0] sum;
		logic [31:0] ns;
		int unsigned hz;
		r = '{default: '0};
		r.ticks_left = hz_countdown;
		case (c.op)
			MODE_TICK: begin
				sum = {2'b00, clk_nsec} + {8'h00, res_ns};
				if (sum < NS_PER_SEC) begin
					clk_nsec = sum[29:0];
				end else begin
					clk_sec = clk_sec + 32'd1;
					clk_nsec = '0;
				end
				// The nanosecond distance is signed, so an earlier alarm in this second fires.
				if (alm_armed && (alm_sec < clk_sec || (alm_sec == clk_sec &&
						longint'(res_half) >= longint'(alm_nsec) - longint'(clk_nsec)))) begin
					ns = {2'b00, clk_nsec} + {9'h000, res_half};
					r.fire_sec = clk_sec;
					if (ns >= NS_PER_SEC) begin
						ns = ns - NS_PER_SEC;
						r.fire_sec = clk_sec + 32'd1;
					end
					r.fire_nsec = ns[29:0];
					r.alarm_fired = 1'b1;
					alm_armed = 1'b0;
				end
				if (hz_countdown <= 5'd1) begin
					r.ticks_left = '0;
					if (res_pending != '0) begin
						res_ns = res_pending;
						hz = (NS_PER_SEC / res_ns) / TICK_HZ;
						if (hz < 1) hz = 1;
						if (hz > 31) hz = 31;
						hz_reload = 5'(hz);
						res_half = res_ns[23:1];
						res_pending = '0;
						r.rate_changed = 1'b1;
					end
					hz_countdown = hz_reload;
				end else begin
					hz_countdown = hz_countdown - 5'd1;
					r.ticks_left = hz_countdown;
				end
			end
			MODE_SET_TIME: begin
				clk_sec = c.sec;
				clk_nsec = c.nsec;
				alm_armed = 1'b0;
			end
			MODE_SET_ALARM: begin
				alm_sec = c.sec;
				alm_nsec = c.nsec;
				alm_armed = 1'b1;
			end
			default: begin
				if (c.req < MIN_RES || c.req > MAX_RES || (c.req % MIN_RES) != 0)
					r.status = 1'b1;
				else if (c.req != res_ns)
					res_pending = c.req;
			end
		endcase
		r.now_sec = clk_sec;
		r.now_nsec = clk_nsec;
		r.resolution_now = res_ns;
	endtask

	function automatic logic [29:0] any_nsec();
		if ($urandom_range(0, 7) == 0)
			return 30'($urandom);
		return 30'($urandom_range(0, NS_PER_SEC - 1));
	endfunction

	function automatic logic [23:0] random_request();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return 24'($urandom);
			2: return 24'($urandom_range(1, RES_STEPS) * MIN_RES + $urandom_range(1, 9));
			3: return 24'(MAX_RES + MIN_RES * $urandom_range(1, 12));
			4: return 24'(MIN_RES - $urandom_range(1, 1000));
			default: return 24'($urandom_range(1, RES_STEPS) * MIN_RES);
		endcase
	endfunction

	task automatic push_cmd(input mode_t op, input logic [31:0] sec, input logic [29:0] nsec,
			input logic [23:0] req);
		command_t c;
		c.op = op;
		c.sec = sec;
		c.nsec = nsec;
		c.req = req;
		pending_commands.push_back(c);
	endtask

	// Arguments that the operation ignores still carry random bits.
	task automatic push_ticks(input int n);
		for (int k = 0; k < n; k++)
			push_cmd(MODE_TICK, $urandom, any_nsec(), 24'($urandom));
	endtask

	task automatic build_commands();
		logic [31:0] base_sec;
		logic [29:0] base_nsec;
		logic [31:0] asec;
		logic [29:0] ansec;
		longint      total;
		int          span;

		base_sec = '0;

		// Directed opening, starting from the reset resolution.
		push_ticks(1);
		push_cmd(MODE_SET_TIME, 32'd7, 30'd986000000, 24'($urandom));
		push_cmd(MODE_SET_ALARM, 32'd7, 30'd999000000, 24'($urandom));
		push_ticks(1);
		push_cmd(MODE_REQ_RES, $urandom, any_nsec(), 24'd0);
		push_cmd(MODE_REQ_RES, $urandom, any_nsec(), 24'(MIN_RES + 1));
		push_cmd(MODE_REQ_RES, $urandom, any_nsec(), 24'(MAX_RES + MIN_RES));
		push_cmd(MODE_REQ_RES, $urandom, any_nsec(), 24'hFFFFFF);
		push_cmd(MODE_REQ_RES, $urandom, any_nsec(), 24'(MIN_RES));
		push_cmd(MODE_REQ_RES, $urandom, any_nsec(), 24'(MAX_RES));
		push_ticks(1);
		push_cmd(MODE_SET_TIME, 32'hFFFFFFFF, 30'd999999999, 24'($urandom));
		push_ticks(1);
		push_cmd(MODE_SET_TIME, 32'd5, 30'h3FFFFFFF, 24'($urandom));
		push_ticks(1);
		push_cmd(MODE_SET_ALARM, 32'd6, 30'd0, 24'($urandom));
		push_ticks(1);
		push_cmd(MODE_SET_ALARM, 32'd5, 30'd999999999, 24'($urandom));
		push_ticks(1);
		push_cmd(MODE_SET_ALARM, 32'd6, 30'd1750000, 24'($urandom));
		push_ticks(1);
		push_cmd(MODE_SET_ALARM, 32'd6, 30'd2250001, 24'($urandom));
		push_ticks(1);
		push_cmd(MODE_SET_TIME, 32'd0, 30'd0, 24'($urandom));
		push_cmd(MODE_REQ_RES, $urandom, any_nsec(), 24'(MAX_RES));

		while (pending_commands.size() < ITEM_TARGET) begin
			case ($urandom_range(0, 99)) inside
				[0:39]: begin
					// Set the time, arm an alarm a little ahead or behind, then tick toward it.
					// Without a new time the alarm is placed near the start of the second last set here.
					if ($urandom_range(0, 3) != 0) begin
						base_sec = ($urandom_range(0, 9) == 0) ? 32'hFFFFFFFF : 32'($urandom);
						base_nsec = 30'($urandom_range(0, NS_PER_SEC - 1));
						push_cmd(MODE_SET_TIME, base_sec, base_nsec, 24'($urandom));
					end else begin
						base_nsec = '0;
					end
					span = ($urandom_range(0, 2) == 0) ? 150000000 : 25000000;
					total = longint'(base_nsec) + longint'($urandom_range(0, span)) - 10000000;
					if (total < 0) begin
						asec = base_sec - 32'd1;
						ansec = 30'(total + NS_L);
					end else begin
						asec = base_sec + 32'(total / NS_L);
						ansec = 30'(total % NS_L);
					end
					push_cmd(MODE_SET_ALARM, asec, ansec, 24'($urandom));
					push_ticks($urandom_range(3, 40));
					if ($urandom_range(0, 7) == 0)
						push_cmd(MODE_SET_TIME, $urandom, any_nsec(), 24'($urandom));
				end
				[40:59]: begin
					push_cmd(MODE_REQ_RES, $urandom, any_nsec(), random_request());
					if ($urandom_range(0, 3) == 0)
						push_cmd(MODE_REQ_RES, $urandom, any_nsec(), random_request());
					push_ticks($urandom_range(1, 25));
				end
				[60:74]: push_ticks($urandom_range(1, 30));
				[75:84]: begin
					// Run the seconds across the top of their range.
					push_cmd(MODE_SET_TIME, 32'hFFFFFFFF - $urandom_range(0, 1),
						30'(NS_PER_SEC - $urandom_range(0, 30000000)), 24'($urandom));
					if ($urandom_range(0, 1) == 0)
						push_cmd(MODE_SET_ALARM, 32'($urandom_range(0, 1)),
							30'($urandom_range(0, 20000000)), 24'($urandom));
					push_ticks($urandom_range(1, 12));
				end
				default: begin
					for (int k = $urandom_range(1, 8); k > 0; k--)
						push_cmd(mode_t'($urandom_range(0, 3)), $urandom, any_nsec(),
							random_request());
				end
			endcase
		end
	endtask

	// Quiet stretches and busy stretches, chosen at random, follow each other on each side.
	function automatic int draw_wait(inout int phase_left, inout bit busy);
		if (phase_left == 0) begin
			busy = $urandom_range(0, 1);
			phase_left = $urandom_range(20, 150);
		end
		phase_left--;
		return busy ? int'($urandom_range(0, MAX_WAIT)) : 0;
	endfunction

	function automatic void check_field(string name, longint unsigned exp_v,
			longint unsigned act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, actual %0d", name, exp_v, act_v);
			errors++;
		end
	endfunction

	// Input side: predicts each accepted transaction and offers the next one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			mode <= MODE_TICK;
			arg_sec <= '0;
			arg_nsec <= '0;
			req_resolution <= '0;
			tx_gap <= 0;
			commands_sent <= 0;
			reset_clock_model();
		end else begin
			if (in_valid && !in_stall) begin
				next_cmd.op = mode_t'(mode);
				next_cmd.sec = arg_sec;
				next_cmd.nsec = arg_nsec;
				next_cmd.req = req_resolution;
				advance_clock(next_cmd, predicted_reading);
				expected_readings.push_back(predicted_reading);
				commands_sent <= commands_sent + 1;
			end
			if (in_valid && in_stall) begin
				// The offered transaction stays put until it is taken.
			end else if (tx_gap != 0) begin
				in_valid <= 1'b0;
				tx_gap <= tx_gap - 1;
			end else if (pending_commands.size() != 0) begin
				next_cmd = pending_commands.pop_front();
				mode <= next_cmd.op;
				arg_sec <= next_cmd.sec;
				arg_nsec <= next_cmd.nsec;
				req_resolution <= next_cmd.req;
				in_valid <= 1'b1;
				tx_gap <= draw_wait(tx_phase_left, tx_busy);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Output side: checks each result and paces the stall.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			rx_wait = 0;
			readings_seen = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_readings.size() == 0) begin
					$error("result transaction arrived with none expected");
					errors++;
				end else begin
					want = expected_readings.pop_front();
					check_field("status", want.status, status);
					check_field("now_sec", want.now_sec, now_sec);
					check_field("now_nsec", want.now_nsec, now_nsec);
					check_field("alarm_fired", want.alarm_fired, alarm_fired);
					check_field("fire_sec", want.fire_sec, fire_sec);
					check_field("fire_nsec", want.fire_nsec, fire_nsec);
					check_field("ticks_left", want.ticks_left, ticks_left);
					check_field("rate_changed", want.rate_changed, rate_changed);
					check_field("resolution_now", want.resolution_now, resolution_now);
				end
				readings_seen++;
				rx_wait = draw_wait(rx_phase_left, rx_busy);
				// One long hold-off lets the block back up into its input.
				if (readings_seen == PRESSURE_AT)
					rx_wait = PRESSURE_CYCLES;
			end else if (rx_wait != 0) begin
				rx_wait--;
			end
			out_stall <= (rx_wait != 0);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$error("no transaction for %0d cycles", IDLE_LIMIT);
			$display("** tick_clock_with_alarm: FAILED **");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		build_commands();
		command_total = pending_commands.size();
		repeat (11) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		while (commands_sent != command_total || expected_readings.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("** tick_clock_with_alarm: PASSED **");
		else
			$display("** tick_clock_with_alarm: FAILED **");
		$finish;
	end

endmodule
